>>> design/ps2h_pkg.sv
package ps2h_pkg;

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_INHIBIT,
        TX_SEND,
        TX_ACKWAIT
    } tx_phase_t;

    localparam logic [1:0] RX_OK        = 2'd0;
    localparam logic [1:0] RX_BAD_START = 2'd1;
    localparam logic [1:0] RX_BAD_STOP  = 2'd2;
    localparam logic [1:0] RX_BAD_PAR   = 2'd3;

    localparam int          ADDR_WIDTH = 4;
    localparam logic [1:0]  REG_IGNORE_START  = 2'd0;
    localparam logic [1:0]  REG_IGNORE_STOP   = 2'd1;
    localparam logic [1:0]  REG_IGNORE_PARITY = 2'd2;
    localparam logic [1:0]  REG_INHIBIT_TICKS = 2'd3;
    localparam logic [15:0] INHIBIT_RESET     = 16'd120;

    localparam logic [3:0]  RX_LAST_BIT = 4'd10;
    localparam logic [3:0]  TX_LAST_BIT = 4'd10;

    typedef struct packed {
        logic        ignore_start;
        logic        ignore_stop;
        logic        ignore_parity;
        logic [15:0] inhibit_ticks;
    } cfg_t;

    typedef struct packed {
        logic       command;
        logic       clock_line;
        logic       data_line;
        logic [7:0] tx_byte;
    } item_t;

    typedef struct packed {
        logic       drive_clock_low;
        logic       drive_data_low;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [1:0] rx_error;
        logic       tx_done;
        logic       tx_rejected;
    } res_t;

endpackage

>>> design/ps2h_core.sv
module ps2h_core
    import ps2h_pkg::*;
#(
    parameter int INHIBIT_COUNT_WIDTH = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    localparam int W = INHIBIT_COUNT_WIDTH;
    localparam logic [W-1:0] CMAX = '1;

    logic            last_clock_reg;
    logic [10:0]     rx_shift_reg, rx_shift_next;
    logic [3:0]      rx_bit_count_reg, rx_bit_count_next;
    tx_phase_t       tx_phase_reg, tx_phase_next;
    logic [9:0]      tx_frame_reg, tx_frame_next;
    logic [3:0]      tx_bit_count_reg, tx_bit_count_next;
    logic [W-1:0]    inhibit_count_reg, inhibit_count_next;

    logic            fall, rise, start_tx;
    logic [31:0]     ticks_ext;
    logic [W-1:0]    inhibit_load, inhibit_dec;
    logic [10:0]     rx_shifted;
    logic            tx_done;
    logic            rx_valid;
    logic [7:0]      rx_byte;
    logic [1:0]      rx_error;
    logic [3:0]      tx_bit_idx;

    assign fall     = last_clock_reg & ~item.clock_line;
    assign rise     = ~last_clock_reg & item.clock_line;
    assign start_tx = item.command && (tx_phase_reg == TX_IDLE);

    // zero acts as one; clamp to counter range
    assign ticks_ext   = 32'(cfg.inhibit_ticks);
    assign inhibit_dec = inhibit_count_reg - W'(1);

    always_comb
    begin
        if (ticks_ext == 32'd0)
            inhibit_load = W'(1);
        else if (ticks_ext > 32'(CMAX))
            inhibit_load = CMAX;
        else
            inhibit_load = W'(ticks_ext);
    end

    // transmit sequencer: next state
    always_comb
    begin
        tx_phase_next      = tx_phase_reg;
        tx_frame_next      = tx_frame_reg;
        tx_bit_count_next  = tx_bit_count_reg;
        inhibit_count_next = inhibit_count_reg;
        tx_done            = 1'b0;
        if (start_tx)
        begin
            tx_frame_next      = {1'b1, ~(^item.tx_byte), item.tx_byte};
            tx_phase_next      = TX_INHIBIT;
            inhibit_count_next = inhibit_load;
            tx_bit_count_next  = 4'd0;
        end
        else
        begin
            case (tx_phase_reg)
                TX_INHIBIT:
                begin
                    inhibit_count_next = inhibit_dec;
                    if (inhibit_dec == '0)
                    begin
                        tx_phase_next     = TX_SEND;
                        tx_bit_count_next = 4'd0;
                    end
                end
                TX_SEND:
                begin
                    if (fall)
                    begin
                        if (tx_bit_count_reg >= TX_LAST_BIT)
                            tx_phase_next = TX_ACKWAIT;
                        else
                            tx_bit_count_next = tx_bit_count_reg + 4'd1;
                    end
                end
                TX_ACKWAIT:
                begin
                    if (rise)
                    begin
                        tx_done           = 1'b1;
                        tx_phase_next     = TX_IDLE;
                        tx_bit_count_next = 4'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // receiver
    assign rx_shifted = {item.data_line, rx_shift_reg[10:1]};

    always_comb
    begin
        rx_shift_next     = rx_shift_reg;
        rx_bit_count_next = rx_bit_count_reg;
        rx_valid          = 1'b0;
        rx_byte           = 8'd0;
        rx_error          = RX_OK;
        if (start_tx)
        begin
            rx_shift_next     = 11'd0;
            rx_bit_count_next = 4'd0;
        end
        else if ((tx_phase_reg == TX_IDLE) && fall)
        begin
            rx_shift_next     = rx_shifted;
            rx_bit_count_next = rx_bit_count_reg + 4'd1;
            if (rx_bit_count_reg >= RX_LAST_BIT)
            begin
                rx_valid = 1'b1;
                rx_byte  = rx_shifted[8:1];
                if (rx_shifted[0] && !cfg.ignore_start)
                    rx_error = RX_BAD_START;
                else if (!rx_shifted[10] && !cfg.ignore_stop)
                    rx_error = RX_BAD_STOP;
                else if (!(^rx_shifted[9:1]) && !cfg.ignore_parity)
                    rx_error = RX_BAD_PAR;
                rx_shift_next     = 11'd0;
                rx_bit_count_next = 4'd0;
            end
        end
    end

    // outputs: line drives follow the updated state
    assign tx_bit_idx = tx_bit_count_next - 4'd1;

    always_comb
    begin
        res.drive_clock_low = (tx_phase_next == TX_INHIBIT);
        res.drive_data_low  = 1'b0;
        if (tx_phase_next == TX_SEND)
        begin
            if (tx_bit_count_next == 4'd0)
                res.drive_data_low = 1'b1;
            else if (tx_bit_count_next <= TX_LAST_BIT)
                res.drive_data_low = ~tx_frame_next[tx_bit_idx];
        end
        res.rx_valid    = rx_valid;
        res.rx_byte     = rx_byte;
        res.rx_error    = rx_error;
        res.tx_done     = tx_done;
        res.tx_rejected = item.command && (tx_phase_reg != TX_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_clock_reg    <= 1'b1;
            rx_shift_reg      <= 11'd0;
            rx_bit_count_reg  <= 4'd0;
            tx_phase_reg      <= TX_IDLE;
            tx_frame_reg      <= 10'd0;
            tx_bit_count_reg  <= 4'd0;
            inhibit_count_reg <= '0;
        end
        else if (step)
        begin
            last_clock_reg    <= item.clock_line;
            rx_shift_reg      <= rx_shift_next;
            rx_bit_count_reg  <= rx_bit_count_next;
            tx_phase_reg      <= tx_phase_next;
            tx_frame_reg      <= tx_frame_next;
            tx_bit_count_reg  <= tx_bit_count_next;
            inhibit_count_reg <= inhibit_count_next;
        end
    end

endmodule

>>> design/ps2_host_frame_interface_unit.sv
// PS/2 host frame interface.
// Input channel (in_valid/in_stall): one beat per line sample tick, carrying
// the sampled clock and data levels, a transmit command and the byte to send.
// Output channel (out_valid/out_stall): exactly one result beat per input
// beat, in order: line drive levels after the tick, a received byte with its
// error code, and transmit done / rejected flags.
// A beat is taken into the input register, then processed into the result
// register once that is free and shown from then on (two register stages).
// Throughput: one beat per cycle while out_stall is low; every tick is a
// single pass of logic between the input register and the result register.
// When out_stall is high the result register holds; one more beat is taken
// into the input register, then in_stall rises until the result is taken.
// Reset (rst_n low, asynchronous) empties both stages, releases both lines,
// drops any partial frame and sets the config registers to their defaults
// (checks enabled, inhibit of 120 ticks).
// The APB port sets the check-ignore flags and the inhibit length; write it
// only while no beats are in flight.
module ps2_host_frame_interface_unit
    import ps2h_pkg::*;
#(
    parameter int INHIBIT_COUNT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic                  clock_line,
    input  logic                  data_line,
    input  logic [7:0]            tx_byte,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  drive_clock_low,
    output logic                  drive_data_low,
    output logic                  rx_valid,
    output logic [7:0]            rx_byte,
    output logic [1:0]            rx_error,
    output logic                  tx_done,
    output logic                  tx_rejected,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t       cfg_reg;
    logic       in_valid_reg, in_valid_next;
    item_t      item_reg;
    logic       out_valid_reg, out_valid_next;
    res_t       res_reg, res_next;
    logic       in_accept, out_free, advance, cfg_write;
    logic [1:0] reg_idx;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ignore_start  <= 1'b0;
            cfg_reg.ignore_stop   <= 1'b0;
            cfg_reg.ignore_parity <= 1'b0;
            cfg_reg.inhibit_ticks <= INHIBIT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_IGNORE_START:  cfg_reg.ignore_start  <= pwdata[0];
                REG_IGNORE_STOP:   cfg_reg.ignore_stop   <= pwdata[0];
                REG_IGNORE_PARITY: cfg_reg.ignore_parity <= pwdata[0];
                REG_INHIBIT_TICKS: cfg_reg.inhibit_ticks <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IGNORE_START:  prdata = {31'd0, cfg_reg.ignore_start};
            REG_IGNORE_STOP:   prdata = {31'd0, cfg_reg.ignore_stop};
            REG_IGNORE_PARITY: prdata = {31'd0, cfg_reg.ignore_parity};
            REG_INHIBIT_TICKS: prdata = {16'd0, cfg_reg.inhibit_ticks};
            default:           prdata = 32'd0;
        endcase
    end

    // beat flow
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.command    <= command;
            item_reg.clock_line <= clock_line;
            item_reg.data_line  <= data_line;
            item_reg.tx_byte    <= tx_byte;
        end
    end

    ps2h_core #(
        .INHIBIT_COUNT_WIDTH (INHIBIT_COUNT_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    assign out_valid       = out_valid_reg;
    assign drive_clock_low = res_reg.drive_clock_low;
    assign drive_data_low  = res_reg.drive_data_low;
    assign rx_valid        = res_reg.rx_valid;
    assign rx_byte         = res_reg.rx_byte;
    assign rx_error        = res_reg.rx_error;
    assign tx_done         = res_reg.tx_done;
    assign tx_rejected     = res_reg.tx_rejected;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result stage can drain");

    a_no_frame_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !rx_valid) |-> (rx_byte == 8'd0 && rx_error == RX_OK))
        else $error("rx payload without a received frame");

    a_rx_not_during_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rx_valid) |-> (!tx_done && !drive_clock_low && !drive_data_low))
        else $error("frame received while transmit active");

    a_inhibit_data_released: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drive_clock_low) |-> !drive_data_low)
        else $error("data driven during clock inhibit");

endmodule

>>> dv/tb_ps2_host_frame_interface_unit.sv
module tb_ps2_host_frame_interface_unit;
    import ps2h_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  command = 1'b0;
    logic                  clock_line = 1'b1;
    logic                  data_line = 1'b1;
    logic [7:0]            tx_byte = 8'd0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  drive_clock_low;
    logic                  drive_data_low;
    logic                  rx_valid;
    logic [7:0]            rx_byte;
    logic [1:0]            rx_error;
    logic                  tx_done;
    logic                  tx_rejected;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // line model state
    cfg_t       cfg = '{1'b0, 1'b0, 1'b0, INHIBIT_RESET};
    logic       last_clk = 1'b1;
    logic [10:0] rx_sr = '0;
    logic [3:0] rx_cnt = '0;
    tx_phase_t  tx_ph = TX_IDLE;
    logic [9:0] tx_sr = '0;
    logic [3:0] tx_cnt = '0;
    logic [15:0] inh_left = '0;

    res_t exp_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int n_beats = 0;
    int n_frames = 0;
    int n_flagged = 0;
    int n_sent = 0;
    int n_dropped = 0;

    ps2_host_frame_interface_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .clock_line      (clock_line),
        .data_line       (data_line),
        .tx_byte         (tx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .drive_clock_low (drive_clock_low),
        .drive_data_low  (drive_data_low),
        .rx_valid        (rx_valid),
        .rx_byte         (rx_byte),
        .rx_error        (rx_error),
        .tx_done         (tx_done),
        .tx_rejected     (tx_rejected),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #4 clk = ~clk;

    // one line tick through the host model
    function automatic res_t line_tick(input item_t it);
        res_t r;
        logic fall;
        logic rise;
        logic started;
        r = '0;
        started = 1'b0;
        fall = last_clk && !it.clock_line;
        rise = !last_clk && it.clock_line;
        if (it.command) begin
            if (tx_ph == TX_IDLE) begin
                tx_sr = {1'b1, ~^it.tx_byte, it.tx_byte};
                tx_ph = TX_INHIBIT;
                inh_left = (cfg.inhibit_ticks == 16'd0) ? 16'd1 : cfg.inhibit_ticks;
                tx_cnt = '0;
                rx_cnt = '0;
                rx_sr = '0;
                started = 1'b1;
            end
            else
            begin
                r.tx_rejected = 1'b1;
            end
        end
        if (!started) begin
            case (tx_ph)
                TX_INHIBIT:
                begin
                    inh_left = inh_left - 16'd1;
                    if (inh_left == 16'd0) begin
                        tx_ph = TX_SEND;
                        tx_cnt = '0;
                    end
                end
                TX_SEND:
                begin
                    if (fall) begin
                        if (tx_cnt >= TX_LAST_BIT)
                            tx_ph = TX_ACKWAIT;
                        else
                            tx_cnt = tx_cnt + 4'd1;
                    end
                end
                TX_ACKWAIT:
                begin
                    if (rise) begin
                        r.tx_done = 1'b1;
                        tx_ph = TX_IDLE;
                        tx_cnt = '0;
                    end
                end
                default:
                begin
                    if (fall) begin
                        rx_sr = {it.data_line, rx_sr[10:1]};
                        rx_cnt = rx_cnt + 4'd1;
                        if (rx_cnt > RX_LAST_BIT) begin
                            r.rx_valid = 1'b1;
                            r.rx_byte = rx_sr[8:1];
                            if (rx_sr[0] && !cfg.ignore_start)
                                r.rx_error = RX_BAD_START;
                            else if (!rx_sr[10] && !cfg.ignore_stop)
                                r.rx_error = RX_BAD_STOP;
                            else if (!(^rx_sr[9:1]) && !cfg.ignore_parity)
                                r.rx_error = RX_BAD_PAR;
                            else
                                r.rx_error = RX_OK;
                            rx_cnt = '0;
                            rx_sr = '0;
                        end
                    end
                end
            endcase
        end
        last_clk = it.clock_line;
        r.drive_clock_low = (tx_ph == TX_INHIBIT);
        if (tx_ph == TX_SEND) begin
            if (tx_cnt == 4'd0)
                r.drive_data_low = 1'b1;
            else if (tx_cnt <= TX_LAST_BIT)
                r.drive_data_low = ~tx_sr[tx_cnt - 4'd1];
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic int half_len();
        return ($urandom_range(9) < 8) ? 1 : int'($urandom_range(2, 3));
    endfunction

    task automatic send_beat(input logic cmd, input logic cl, input logic dl,
                             input logic [7:0] b);
        item_t it;
        it.command = cmd;
        it.clock_line = cl;
        it.data_line = dl;
        it.tx_byte = b;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        command <= cmd;
        clock_line <= cl;
        data_line <= dl;
        tx_byte <= b;
        do @(posedge clk); while (in_stall);
        exp_q.push_back(line_tick(it));
        n_beats++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        logic [31:0] want;
        want = (idx == REG_INHIBIT_TICKS) ? {16'd0, val} : {31'd0, val[0]};
        in_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge clk);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= want;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IGNORE_START:  cfg.ignore_start = val[0];
            REG_IGNORE_STOP:   cfg.ignore_stop = val[0];
            REG_IGNORE_PARITY: cfg.ignore_parity = val[0];
            default:           cfg.inhibit_ticks = val;
        endcase
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        check_field("prdata", want, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // device-to-host frame, start bit first; nbits < 11 leaves a partial frame
    task automatic device_frame(input logic [7:0] d, input logic st, input logic sp,
                                input logic pb, input int nbits);
        logic [10:0] f;
        int hi;
        int lo;
        f = {sp, pb, d, st};
        for (int i = 0; i < nbits; i++) begin
            hi = half_len();
            lo = half_len();
            repeat (hi) send_beat(1'b0, 1'b1, f[i], 8'($urandom_range(255)));
            repeat (lo) send_beat(1'b0, 1'b0, f[i], 8'($urandom_range(255)));
        end
        send_beat(1'b0, 1'b1, 1'b1, 8'($urandom_range(255)));
    endtask

    // host-to-device transfer: command, clock held low, 11 device clocks, release
    task automatic host_send(input logic [7:0] d, input int poke_pct);
        int n;
        int hi;
        int lo;
        n = (cfg.inhibit_ticks == 16'd0) ? 1 : cfg.inhibit_ticks;
        send_beat(1'b1, 1'b1, 1'b1, d);
        repeat (n)
            send_beat($urandom_range(99) < poke_pct, 1'b0, 1'($urandom_range(1)),
                      8'($urandom_range(255)));
        repeat (11) begin
            hi = half_len();
            lo = half_len();
            repeat (hi)
                send_beat($urandom_range(99) < poke_pct, 1'b1, 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            repeat (lo)
                send_beat($urandom_range(99) < poke_pct, 1'b0, 1'($urandom_range(1)),
                          8'($urandom_range(255)));
        end
        send_beat(1'b0, 1'b1, 1'b1, 8'($urandom_range(255)));
    endtask

    task automatic test_rx_checks();
        device_frame(8'h00, 1'b0, 1'b1, ~^8'h00, 11);
        device_frame(8'hFF, 1'b0, 1'b1, ~^8'hFF, 11);
        device_frame(8'hA5, 1'b1, 1'b1, ~^8'hA5, 11);
        device_frame(8'h5A, 1'b0, 1'b0, ~^8'h5A, 11);
        device_frame(8'h3C, 1'b0, 1'b1, ^8'h3C, 11);
        device_frame(8'h81, 1'b1, 1'b0, ^8'h81, 11);
    endtask

    task automatic test_ignore_flags();
        write_reg(REG_IGNORE_START, 16'd1);
        device_frame(8'hC3, 1'b1, 1'b0, ~^8'hC3, 11);
        write_reg(REG_IGNORE_STOP, 16'd1);
        device_frame(8'h7E, 1'b1, 1'b0, ^8'h7E, 11);
        write_reg(REG_IGNORE_PARITY, 16'd1);
        device_frame(8'h18, 1'b1, 1'b0, ^8'h18, 11);
        write_reg(REG_IGNORE_START, 16'd0);
        write_reg(REG_IGNORE_STOP, 16'd0);
        write_reg(REG_IGNORE_PARITY, 16'd0);
    endtask

    task automatic test_tx_inhibit();
        // partial frame is dropped when the command lands
        device_frame(8'h55, 1'b0, 1'b1, ~^8'h55, 4);
        host_send(8'h96, 10);
        write_reg(REG_INHIBIT_TICKS, 16'd0);
        host_send(8'h00, 0);
        write_reg(REG_INHIBIT_TICKS, 16'd1);
        host_send(8'hFF, 50);
        device_frame(8'h6B, 1'b0, 1'b1, ~^8'h6B, 11);
    endtask

    task automatic test_random_traffic(input int beats);
        int stop_at;
        int pick;
        logic [7:0] d;
        write_reg(REG_IGNORE_START, 16'($urandom_range(1)));
        write_reg(REG_IGNORE_STOP, 16'($urandom_range(1)));
        write_reg(REG_IGNORE_PARITY, 16'($urandom_range(1)));
        write_reg(REG_INHIBIT_TICKS, 16'($urandom_range(0, 6)));
        stop_at = n_beats + beats;
        while (n_beats < stop_at) begin
            pick = $urandom_range(99);
            d = 8'($urandom_range(255));
            if (pick < 55)
                device_frame(d, 1'b0, 1'b1, ~^d, 11);
            else if (pick < 70)
                device_frame(d, $urandom_range(3) == 0, $urandom_range(3) != 0,
                             (~^d) ^ ($urandom_range(3) == 0), 11);
            else if (pick < 78)
                device_frame(d, 1'b0, 1'b1, ~^d, $urandom_range(1, 10));
            else if (pick < 90)
                host_send(d, 5);
            else
                repeat ($urandom_range(1, 6))
                    send_beat($urandom_range(19) == 0, 1'($urandom_range(1)),
                              1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    task automatic test_long_inhibit();
        // largest inhibit length: register range only
        write_reg(REG_INHIBIT_TICKS, 16'hFFFF);
        write_reg(REG_INHIBIT_TICKS, INHIBIT_RESET);
    endtask

    task automatic test_backpressure();
        logic [7:0] d;
        d = 8'($urandom_range(255));
        hold_left = 300;
        device_frame(d, 1'b0, 1'b1, ~^d, 11);
        in_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge clk);
        d = 8'($urandom_range(255));
        device_frame(d, 1'b0, 1'b1, ~^d, 11);
    endtask

    always @(posedge clk) begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (exp_q.size() == 0) begin
                $error("result beat with no expected result");
                fail_count++;
            end
            else
            begin
                want = exp_q.pop_front();
                check_field("drive_clock_low", 32'(want.drive_clock_low),
                            32'(drive_clock_low));
                check_field("drive_data_low", 32'(want.drive_data_low),
                            32'(drive_data_low));
                check_field("rx_valid", 32'(want.rx_valid), 32'(rx_valid));
                check_field("rx_byte", 32'(want.rx_byte), 32'(rx_byte));
                check_field("rx_error", 32'(want.rx_error), 32'(rx_error));
                check_field("tx_done", 32'(want.tx_done), 32'(tx_done));
                check_field("tx_rejected", 32'(want.tx_rejected), 32'(tx_rejected));
                if (want.rx_valid) n_frames++;
                if (want.rx_valid && want.rx_error != RX_OK) n_flagged++;
                if (want.tx_done) n_sent++;
                if (want.tx_rejected) n_dropped++;
            end
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 24;
        recv_idle_pct = 83;
        test_rx_checks();
        test_ignore_flags();
        test_tx_inhibit();
        test_random_traffic(20);
        send_idle_pct = 83;
        recv_idle_pct = 24;
        test_random_traffic(20);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(20);
        test_long_inhibit();
        test_backpressure();
        in_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Ran %0d line ticks: %0d frames received (%0d flagged), %0d transmits done,",
                 n_beats, n_frames, n_flagged, n_sent);
        $display("%0d commands dropped while busy, inhibit lengths 0 to 6 and 120.", n_dropped);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
design/ps2h_pkg.sv
design/ps2h_core.sv
design/ps2_host_frame_interface_unit.sv
dv/tb_ps2_host_frame_interface_unit.sv
